// File: rtl/ntv_pkg.sv
`timescale 1ns / 1ps

package ntv_pkg;

   // Controller states of the evaluator core.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_DRAIN,
      ST_UPD_READ,
      ST_UPD_WAIT,
      ST_FINISH
   } state_type;

   // Command codes.
   localparam logic CMD_EVAL   = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   // Field widths.
   localparam int CELL_W   = 4;
   localparam int BOARD_W  = 64;
   localparam int TID_IN_W = 4;
   localparam int WIDX_W   = 16;
   localparam int WEIGHT_W = 32;
   localparam int VALUE_W  = 36;
   localparam int MAX_TUPLES = 14;
   localparam int MAX_LEN    = 4;

   // Saturation limits of a Q16.16 weight.
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 32'h7FFF_FFFF;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 32'h8000_0000;

   // Board cells of each tuple; the first cell is the low nibble of the index.
   localparam logic [CELL_W-1:0] TUPLE_CELLS [0:MAX_TUPLES-1][0:MAX_LEN-1] = '{
      '{4'd0,  4'd1,  4'd2,  4'd3},
      '{4'd4,  4'd5,  4'd6,  4'd7},
      '{4'd8,  4'd9,  4'd10, 4'd11},
      '{4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd0,  4'd4,  4'd8,  4'd12},
      '{4'd1,  4'd5,  4'd9,  4'd13},
      '{4'd2,  4'd6,  4'd10, 4'd14},
      '{4'd3,  4'd7,  4'd11, 4'd15},
      '{4'd0,  4'd1,  4'd4,  4'd5},
      '{4'd2,  4'd3,  4'd6,  4'd7},
      '{4'd8,  4'd9,  4'd12, 4'd13},
      '{4'd10, 4'd11, 4'd14, 4'd15},
      '{4'd3,  4'd2,  4'd1,  4'd0},
      '{4'd15, 4'd14, 4'd13, 4'd12}
   };

endpackage

// File: rtl/ntv_ram.sv
`timescale 1ns / 1ps

module ntv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one read port with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ntuple_value_evaluator_core.sv
`timescale 1ns / 1ps
// Evaluate: one weight read per tuple through the single read port, issued in ST_EVAL, then
// ST_DRAIN and ST_FINISH. The input reopens in the same cycle as the new result appears.
// Update: ST_UPD_READ reads, ST_UPD_WAIT does the saturating add and write back, ST_FINISH
// loads the result once the output is free; a rejected update goes straight to ST_FINISH.
// After reset a clearing pass writes zero to all NUM_TUPLES * 16^TUPLE_LEN weights, one per
// cycle; req_ready stays low until it ends.

module ntuple_value_evaluator_core #(
   parameter int NUM_TUPLES = 14,
   parameter int TUPLE_LEN  = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [ntv_pkg::BOARD_W-1:0]          req_board,
   input  logic [ntv_pkg::TID_IN_W-1:0]         req_tuple_id,
   input  logic [ntv_pkg::WIDX_W-1:0]           req_weight_index,
   input  logic signed [ntv_pkg::WEIGHT_W-1:0]  req_delta,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [ntv_pkg::VALUE_W-1:0]   rsp_value,
   output logic                                 rsp_rejected
);

   localparam int IDX_W      = ntv_pkg::CELL_W * TUPLE_LEN;
   localparam int TABLE_SIZE = 1 << IDX_W;
   localparam int MEM_DEPTH  = NUM_TUPLES * TABLE_SIZE;
   localparam int MEM_AW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int TID_W      = (NUM_TUPLES > 1) ? $clog2(NUM_TUPLES) : 1;
   localparam int WW         = ntv_pkg::WEIGHT_W;
   localparam int VW         = ntv_pkg::VALUE_W;

   ntv_pkg::state_type state_ff, state_in;

   logic [MEM_AW-1:0]                clr_cnt_ff, clr_cnt_in;
   logic [TID_W-1:0]                 eval_cnt_ff, eval_cnt_in;
   logic                             rd_vld_ff, rd_vld_in;
   logic [VW-1:0]                    res_value_ff, res_value_in;
   logic                             res_rej_ff, res_rej_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                    rsp_value_ff, rsp_value_in;
   logic                             rsp_rej_ff, rsp_rej_in;

   logic [ntv_pkg::BOARD_W-1:0]      board_ff;
   logic [ntv_pkg::TID_IN_W-1:0]     tid_ff;
   logic [ntv_pkg::WIDX_W-1:0]       widx_ff;
   logic [WW-1:0]                    delta_ff;

   logic                             mem_we;
   logic [MEM_AW-1:0]                mem_waddr, mem_raddr;
   logic [WW-1:0]                    mem_wdata, mem_rdata;

   logic                             req_reject;
   logic                             out_free;
   logic [IDX_W-1:0]                 eval_idx;
   logic [MEM_AW-1:0]                eval_addr, upd_addr;
   logic [WW:0]                      upd_sum;
   logic [WW-1:0]                    sat_weight;

   // Weight memory, one 32-bit Q16.16 entry per tuple and index.
   ntv_ram #(
      .WIDTH (WW),
      .DEPTH (MEM_DEPTH)
   ) u_weights (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // An update is refused for a tuple or an index beyond the tables.
   assign req_reject = (req_tuple_id >= ntv_pkg::TID_IN_W'(NUM_TUPLES)) ||
                       ({1'b0, req_weight_index} >= 17'(TABLE_SIZE));

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ntv_pkg::ST_IDLE);

   // Table index of the tuple selected by the evaluate counter.
   always_comb begin
      logic [ntv_pkg::CELL_W-1:0] cell_pos;
      eval_idx = '0;
      for (int i = 0; i < TUPLE_LEN; i++) begin
         cell_pos = ntv_pkg::TUPLE_CELLS[4'(eval_cnt_ff)][i];
         eval_idx[i*ntv_pkg::CELL_W +: ntv_pkg::CELL_W] = board_ff[{cell_pos, 2'b00} +: 4];
      end
   end

   // Memory addresses: tuple number above the table index.
   assign eval_addr = MEM_AW'({4'(eval_cnt_ff), eval_idx});
   assign upd_addr  = MEM_AW'({tid_ff, widx_ff[IDX_W-1:0]});

   // Saturating add of the delta to the stored weight.
   assign upd_sum = {mem_rdata[WW-1], mem_rdata} + {delta_ff[WW-1], delta_ff};
   always_comb begin
      if (upd_sum[WW] != upd_sum[WW-1]) begin
         sat_weight = upd_sum[WW] ? ntv_pkg::WEIGHT_MIN : ntv_pkg::WEIGHT_MAX;
      end else begin
         sat_weight = upd_sum[WW-1:0];
      end
   end

   // Next state and memory control.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      eval_cnt_in  = eval_cnt_ff;
      rd_vld_in    = 1'b0;
      res_value_in = res_value_ff;
      res_rej_in   = res_rej_ff;
      mem_we       = 1'b0;
      mem_waddr    = upd_addr;
      mem_wdata    = sat_weight;
      mem_raddr    = upd_addr;

      case (state_ff)
         ntv_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = '0;
            if (clr_cnt_ff == MEM_AW'(MEM_DEPTH - 1)) begin
               state_in = ntv_pkg::ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ntv_pkg::ST_IDLE: begin
            if (req_valid) begin
               res_value_in = '0;
               res_rej_in   = 1'b0;
               eval_cnt_in  = '0;
               if (req_command == ntv_pkg::CMD_EVAL) begin
                  state_in = ntv_pkg::ST_EVAL;
               end else if (req_reject) begin
                  res_rej_in = 1'b1;
                  state_in   = ntv_pkg::ST_FINISH;
               end else begin
                  state_in = ntv_pkg::ST_UPD_READ;
               end
            end
         end
         ntv_pkg::ST_EVAL: begin
            mem_raddr = eval_addr;
            rd_vld_in = 1'b1;
            if (eval_cnt_ff == TID_W'(NUM_TUPLES - 1)) begin
               state_in = ntv_pkg::ST_DRAIN;
            end else begin
               eval_cnt_in = eval_cnt_ff + 1'b1;
            end
         end
         ntv_pkg::ST_DRAIN: begin
            state_in = ntv_pkg::ST_FINISH;
         end
         ntv_pkg::ST_UPD_READ: begin
            state_in = ntv_pkg::ST_UPD_WAIT;
         end
         ntv_pkg::ST_UPD_WAIT: begin
            mem_we       = 1'b1;
            res_value_in = {{(VW - WW){sat_weight[WW-1]}}, sat_weight};
            state_in     = ntv_pkg::ST_FINISH;
         end
         ntv_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = ntv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ntv_pkg::ST_IDLE;
         end
      endcase

      // Accumulate each weight the cycle after its read.
      if (rd_vld_ff) begin
         res_value_in = res_value_ff + {{(VW - WW){mem_rdata[WW-1]}}, mem_rdata};
      end
   end

   // Result register toward the response channel.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_rej_in   = rsp_rej_ff;
      if ((state_ff == ntv_pkg::ST_FINISH) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res_value_ff;
         rsp_rej_in   = res_rej_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ntv_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         eval_cnt_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         eval_cnt_ff  <= eval_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      res_value_ff <= res_value_in;
      res_rej_ff   <= res_rej_in;
      rsp_value_ff <= rsp_value_in;
      rsp_rej_ff   <= rsp_rej_in;
      if (req_valid && req_ready) begin
         board_ff <= req_board;
         tid_ff   <= req_tuple_id;
         widx_ff  <= req_weight_index;
         delta_ff <= req_delta;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_rejected = rsp_rej_ff;

   // A read result only arrives after an evaluate read was issued.
   assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> ($past(state_ff) == ntv_pkg::ST_EVAL))
      else $error("Read result without an evaluate read.");

   // An accepted item always leaves the idle state.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ntv_pkg::ST_IDLE))
      else $error("Accepted item did not start.");

   // Update write-back only touches an existing tuple table.
   assert property (@(posedge clock) disable iff (reset)
      (mem_we && (state_ff == ntv_pkg::ST_UPD_WAIT)) |->
         (tid_ff < ntv_pkg::TID_IN_W'(NUM_TUPLES)))
      else $error("Weight write to a tuple beyond the tables.");

   // A refused update reports a zero value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rejected) |-> (rsp_value == '0))
      else $error("Refused update with a nonzero value.");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int TUPLE_COUNT    = 14;
   localparam int TABLE_ENTRIES  = 65536;
   localparam int RESULT_LATENCY = 24;
   localparam int RANDOM_ITEMS   = 300;
   localparam int WEIGHT_HI      = 32'h7FFF_FFFF;
   localparam int WEIGHT_LO      = 32'h8000_0000;

   // One expected response: the Q20.16 value and the reject flag.
   typedef struct packed {
      logic signed [ntv_pkg::VALUE_W-1:0] value;
      logic                               rejected;
   } outcome_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic                                req_command = ntv_pkg::CMD_EVAL;
   logic [ntv_pkg::BOARD_W-1:0]         req_board = '0;
   logic [ntv_pkg::TID_IN_W-1:0]        req_tuple_id = '0;
   logic [ntv_pkg::WIDX_W-1:0]          req_weight_index = '0;
   logic signed [ntv_pkg::WEIGHT_W-1:0] req_delta = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [ntv_pkg::VALUE_W-1:0]  rsp_value;
   logic                                rsp_rejected;

   // Shadow copy of the weight tables; entries never written read as zero.
   int          weight_mem [int];
   outcome_type pending_outcomes [$];
   outcome_type head_outcome;
   logic [ntv_pkg::BOARD_W-1:0] board_pool [8];

   int send_idle_pct = 13;
   int rsp_idle_pct = 77;
   int items_sent = 0;
   int error_count = 0;
   int eval_count = 0;
   int update_count = 0;
   int saturate_count = 0;
   int reject_count = 0;

   ntuple_value_evaluator_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_board        (req_board),
      .req_tuple_id     (req_tuple_id),
      .req_weight_index (req_weight_index),
      .req_delta        (req_delta),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value),
      .rsp_rejected     (rsp_rejected)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Gathers the cells of tuple t from the board; the first cell is the low nibble.
   function automatic logic [15:0] tuple_index(logic [ntv_pkg::BOARD_W-1:0] board, int t);
      logic [15:0] cells;
      logic [15:0] idx;
      case (t)
         0:       cells = 16'h3210;
         1:       cells = 16'h7654;
         2:       cells = 16'hBA98;
         3:       cells = 16'hFEDC;
         4:       cells = 16'hC840;
         5:       cells = 16'hD951;
         6:       cells = 16'hEA62;
         7:       cells = 16'hFB73;
         8:       cells = 16'h5410;
         9:       cells = 16'h7632;
         10:      cells = 16'hDC98;
         11:      cells = 16'hFEBA;
         12:      cells = 16'h0123;
         default: cells = 16'hCDEF;
      endcase
      for (int i = 0; i < 4; i++)
         idx[4*i +: 4] = board[4*cells[4*i +: 4] +: 4];
      return idx;
   endfunction

   function automatic int weight_at(int t, logic [15:0] idx);
      int key;
      key = t * TABLE_ENTRIES + int'(idx);
      return weight_mem.exists(key) ? weight_mem[key] : 0;
   endfunction

   // Computes the response of one accepted request and applies any weight change.
   function automatic outcome_type predict_outcome(logic cmd,
                                                   logic [ntv_pkg::BOARD_W-1:0] board,
                                                   logic [ntv_pkg::TID_IN_W-1:0] tid,
                                                   logic [ntv_pkg::WIDX_W-1:0] widx,
                                                   logic signed [ntv_pkg::WEIGHT_W-1:0] delta);
      outcome_type res;
      longint      total;
      res = '0;
      if (cmd == ntv_pkg::CMD_EVAL) begin
         total = 0;
         for (int t = 0; t < TUPLE_COUNT; t++)
            total += weight_at(t, tuple_index(board, t));
         res.value = total[ntv_pkg::VALUE_W-1:0];
         eval_count++;
      end else if (int'(tid) >= TUPLE_COUNT) begin
         res.rejected = 1'b1;
         reject_count++;
      end else begin
         total = longint'(weight_at(int'(tid), widx)) + longint'(delta);
         if (total > longint'(WEIGHT_HI)) begin
            total = WEIGHT_HI;
            saturate_count++;
         end else if (total < longint'(WEIGHT_LO)) begin
            total = WEIGHT_LO;
            saturate_count++;
         end
         weight_mem[int'(tid) * TABLE_ENTRIES + int'(widx)] = total[ntv_pkg::WEIGHT_W-1:0];
         res.value = total[ntv_pkg::VALUE_W-1:0];
         update_count++;
      end
      return res;
   endfunction

   function automatic logic [ntv_pkg::BOARD_W-1:0] random_board();
      return {$urandom, $urandom};
   endfunction

   // Small deltas half the time, with the limits, zero and full-range values mixed in.
   function automatic logic signed [ntv_pkg::WEIGHT_W-1:0] random_delta();
      case ($urandom_range(9))
         0:       return WEIGHT_HI;
         1:       return WEIGHT_LO;
         2:       return '0;
         3, 4:    return $urandom;
         default: return int'($urandom_range(2097151)) - 1048576;
      endcase
   endfunction

   // Drives one request, holds it until the transfer, then records its outcome.
   task automatic send_request(input logic cmd, input logic [ntv_pkg::BOARD_W-1:0] board,
                               input logic [ntv_pkg::TID_IN_W-1:0] tid,
                               input logic [ntv_pkg::WIDX_W-1:0] widx,
                               input logic signed [ntv_pkg::WEIGHT_W-1:0] delta);
      outcome_type expected_outcome;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_board        <= board;
      req_tuple_id     <= tid;
      req_weight_index <= widx;
      req_delta        <= delta;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      expected_outcome = predict_outcome(cmd, board, tid, widx, delta);
      pending_outcomes.insert(pending_outcomes.size(), expected_outcome);
      items_sent++;
   endtask

   // Holds off the sender until every outstanding response has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // Cleared tables, the positive and negative limits and the largest board sum.
   task automatic test_cleared_and_saturated();
      send_request(ntv_pkg::CMD_EVAL, '0, 4'($urandom), 16'($urandom), $urandom);
      send_request(ntv_pkg::CMD_EVAL, '1, 4'($urandom), 16'($urandom), $urandom);
      for (int t = 0; t < TUPLE_COUNT; t++)
         send_request(ntv_pkg::CMD_UPDATE, random_board(), 4'(t), '0, WEIGHT_HI);
      send_request(ntv_pkg::CMD_UPDATE, '0, '0, '0, WEIGHT_HI);
      send_request(ntv_pkg::CMD_EVAL, '0, '1, '1, WEIGHT_LO);
      send_request(ntv_pkg::CMD_UPDATE, '1, '0, '0, WEIGHT_LO);
      send_request(ntv_pkg::CMD_UPDATE, '1, '0, '0, WEIGHT_LO);
      send_request(ntv_pkg::CMD_EVAL, '0, '0, '0, '0);
   endtask

   // Updates aimed at tuple ids past the last table must leave every weight alone.
   task automatic test_rejected_updates();
      send_request(ntv_pkg::CMD_UPDATE, random_board(), 4'd14, '0, WEIGHT_HI);
      send_request(ntv_pkg::CMD_UPDATE, '1, 4'd15, '1, WEIGHT_LO);
      send_request(ntv_pkg::CMD_EVAL, '0, 4'($urandom), 16'($urandom), $urandom);
   endtask

   // Mostly training-like traffic: updates on the tuples of a board, then that board evaluated.
   task automatic test_random_training(input int send_pct, input int rsp_pct);
      int                                  first_item;
      int                                  slot;
      int                                  t;
      int                                  pick;
      logic [ntv_pkg::BOARD_W-1:0]         board;
      logic signed [ntv_pkg::WEIGHT_W-1:0] big;
      send_idle_pct = send_pct;
      rsp_idle_pct = rsp_pct;
      first_item = items_sent;
      foreach (board_pool[i])
         board_pool[i] = random_board();
      while (items_sent - first_item < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            slot = $urandom_range(7);
            if ($urandom_range(9) == 0)
               board_pool[slot] = random_board();
            board = board_pool[slot];
            repeat ($urandom_range(6, 1)) begin
               t = $urandom_range(TUPLE_COUNT - 1);
               send_request(ntv_pkg::CMD_UPDATE, random_board(), 4'(t),
                            tuple_index(board, t), random_delta());
            end
            send_request(ntv_pkg::CMD_EVAL, board, 4'($urandom), 16'($urandom), $urandom);
         end else if (pick < 64) begin
            // Every tuple of a fresh board driven to one limit, twice, to reach the sum extremes.
            board = random_board();
            big = ($urandom_range(1) != 0) ? WEIGHT_HI : WEIGHT_LO;
            repeat (2) begin
               for (int k = 0; k < TUPLE_COUNT; k++)
                  send_request(ntv_pkg::CMD_UPDATE, board, 4'(k), tuple_index(board, k), big);
               send_request(ntv_pkg::CMD_EVAL, board, 4'($urandom), 16'($urandom),
                            $urandom);
            end
         end else if (pick < 65) begin
            wait_for_results();
         end else if ($urandom_range(1) != 0) begin
            send_request(ntv_pkg::CMD_EVAL, random_board(), 4'($urandom), 16'($urandom),
                         $urandom);
         end else begin
            send_request(ntv_pkg::CMD_UPDATE, random_board(), 4'($urandom), 16'($urandom),
                         random_delta());
         end
      end
      wait_for_results();
   endtask

   // The receiver stalls at random according to the current idle profile.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Each response transfer is checked against the oldest outstanding outcome.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response transfer with no outcome pending");
            error_count++;
         end else begin
            head_outcome = pending_outcomes.pop_front();
            if (rsp_value !== head_outcome.value) begin
               $error("value: expected %0d, got %0d", $signed(head_outcome.value),
                      $signed(rsp_value));
               error_count++;
            end
            if (rsp_rejected !== head_outcome.rejected) begin
               $error("rejected: expected %0b, got %0b", head_outcome.rejected,
                      rsp_rejected);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_cleared_and_saturated();
      test_rejected_updates();
      test_random_training(13, 77);
      test_random_training(77, 13);
      test_random_training(0, 0);
      wait_for_results();
      repeat (RESULT_LATENCY) @(posedge clock);
      $display("Checked %0d board evaluations, %0d weight updates (%0d clamped at a limit)",
               eval_count, update_count, saturate_count);
      $display("and %0d refused updates, under three stall profiles on both channels.",
               reject_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // This timeout leaves a wide margin over the clearing pass.
   initial begin
      #80_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
